### sv/mch_pkg.sv
// Package for the magnetometer calibration and heading block.
// Holds the fixed-point formats, command and register codes and the CORDIC angle table.
// No dependencies.
package mch_pkg;

    localparam int WEIGHT_FRAC_BITS = 12;
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_ITERS     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    localparam int AXIS_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = 34;
    localparam int SPAN_W   = 17;
    localparam int SUM_W    = 18;
    localparam int NUM_W    = SPAN_W + WEIGHT_FRAC_BITS;
    localparam int VEC_W    = 27;
    localparam int ANG_W    = 26;
    localparam int ATAN_W   = 22;
    localparam int STEP_W   = 5;
    localparam int DCNT_W   = $clog2(NUM_W + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    localparam logic [2:0] FUNC_SAMPLE    = 3'd0;
    localparam logic [2:0] FUNC_START     = 3'd1;
    localparam logic [2:0] FUNC_STOP      = 3'd2;
    localparam logic [2:0] FUNC_CALIBRATE = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;

    localparam logic REG_NEGATE_XY      = 1'b0;
    localparam logic REG_HEADING_OFFSET = 1'b1;

    typedef logic signed [AXIS_W-1:0] axis_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] r;
        unique case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/magnetometer_calibrate_heading.sv
// Top level of the magnetometer calibration and heading block.
// Sequencer with one shared multiplier, one restoring divider and one CORDIC stage.
// Depends on mch_pkg.
//
// Usage: an input beat carries func and a raw sample; it is taken when in_valid is
// high and in_stall is low. Every input beat gives exactly one output beat, taken
// when out_valid is high and out_stall is low. Configuration writes use cfg_valid
// and cfg_ready (always ready); they must be made while the block is idle, which the
// block itself does not enforce. A sample passes through the shared multiplier once
// for each of the three axes and then through the CORDIC loop. A calibrate runs the
// divider, one quotient bit per cycle, for each axis whose half span is nonzero and
// shares the sign of a nonzero sum. Other commands pass through a single command state.
// One item is worked on at a time; in_stall is high while an item is in progress.
// The result sits in its own output register, so the next item is taken while an
// earlier result still waits. If the receiver stalls and a new result is ready,
// the sequencer holds until the output register frees.
// Reset clears tracking, the range, offsets, the configuration and sets all
// weights to 1.0.
module magnetometer_calibrate_heading
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          func,
    input  logic signed [15:0]  raw_x,
    input  logic signed [15:0]  raw_y,
    input  logic signed [15:0]  raw_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  cal_x,
    output logic signed [15:0]  cal_y,
    output logic signed [15:0]  cal_z,
    output logic signed [9:0]   heading_deg,
    output logic signed [15:0]  min_x,
    output logic signed [15:0]  max_x,
    output logic signed [15:0]  min_y,
    output logic signed [15:0]  max_y,
    output logic signed [15:0]  min_z,
    output logic signed [15:0]  max_z,
    output logic                span_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_SAT    = 4'd3;
    localparam logic [3:0] ST_CINIT  = 4'd4;
    localparam logic [3:0] ST_CSTEP  = 4'd5;
    localparam logic [3:0] ST_HFIN   = 4'd6;
    localparam logic [3:0] ST_CALH   = 4'd7;
    localparam logic [3:0] ST_DSETUP = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_DDONE  = 4'd10;
    localparam logic [3:0] ST_CMD    = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    localparam int W = mch_pkg::WEIGHT_FRAC_BITS;

    logic [3:0]                         state_reg;
    logic [2:0]                         func_reg;
    mch_pkg::axis_t                     v_reg [3];
    mch_pkg::axis_t                     min_reg [3];
    mch_pkg::axis_t                     max_reg [3];
    mch_pkg::axis_t                     off_reg [3];
    logic [mch_pkg::WEIGHT_W-1:0]       wgt_reg [3];
    mch_pkg::axis_t                     cal_reg [3];
    mch_pkg::axis_t                     h_reg [3];
    logic                               tracking_reg;
    logic                               negate_reg;
    logic signed [9:0]                  hoff_reg;
    logic [1:0]                         axis_reg;
    logic signed [mch_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mch_pkg::VEC_W-1:0]   x_reg;
    logic signed [mch_pkg::VEC_W-1:0]   y_reg;
    logic signed [mch_pkg::ANG_W-1:0]   z_reg;
    logic [mch_pkg::STEP_W-1:0]         step_reg;
    logic signed [mch_pkg::SUM_W-1:0]   sum_reg;
    logic [mch_pkg::NUM_W-1:0]          num_reg;
    logic [mch_pkg::SPAN_W-1:0]         den_reg;
    logic [mch_pkg::SPAN_W-1:0]         rem_reg;
    logic [mch_pkg::DCNT_W-1:0]         dcnt_reg;
    logic                               span_reg;
    logic signed [9:0]                  head_reg;

    logic                               ovalid_reg;
    mch_pkg::axis_t                     ocal_reg [3];
    mch_pkg::axis_t                     omin_reg [3];
    mch_pkg::axis_t                     omax_reg [3];
    logic signed [9:0]                  ohead_reg;
    logic                               ospan_reg;

    logic                               in_take;
    logic                               out_free;

    logic signed [16:0]                 diff_w;
    logic signed [mch_pkg::PROD_W-1:0]  adj_w;
    logic signed [mch_pkg::PROD_W-1:0]  shr_w;
    mch_pkg::axis_t                     sat_w;
    logic signed [mch_pkg::VEC_W-1:0]   xs_w;
    logic signed [mch_pkg::VEC_W-1:0]   ys_w;
    logic signed [mch_pkg::ANG_W-1:0]   atan_w;
    logic signed [mch_pkg::ANG_W-1:0]   zadj_w;
    logic signed [9:0]                  deg_w;
    logic signed [10:0]                 hsum_w;
    logic signed [10:0]                 hrem_w;
    logic [mch_pkg::SPAN_W:0]           trial_w;
    logic                               qbit_w;
    logic [mch_pkg::SPAN_W-1:0]         sum_mag_w;
    logic [15:0]                        h_mag_w;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = ovalid_reg;
    assign out_free   = !ovalid_reg || !out_stall;

    assign cal_x       = ocal_reg[0];
    assign cal_y       = ocal_reg[1];
    assign cal_z       = ocal_reg[2];
    assign heading_deg = ohead_reg;
    assign min_x       = omin_reg[0];
    assign max_x       = omax_reg[0];
    assign min_y       = omin_reg[1];
    assign max_y       = omax_reg[1];
    assign min_z       = omin_reg[2];
    assign max_z       = omax_reg[2];
    assign span_error  = ospan_reg;

    always_comb
    begin
        diff_w = {v_reg[axis_reg][15], v_reg[axis_reg]}
               - {off_reg[axis_reg][15], off_reg[axis_reg]};
        adj_w  = prod_reg + ((prod_reg < 0) ? mch_pkg::PROD_W'((1 << W) - 1)
                                            : mch_pkg::PROD_W'(0));
        shr_w  = adj_w >>> W;
        if (shr_w > $signed(mch_pkg::PROD_W'(32767)))
        begin
            sat_w = 16'sh7fff;
        end
        else if (shr_w < -$signed(mch_pkg::PROD_W'(32768)))
        begin
            sat_w = 16'sh8000;
        end
        else
        begin
            sat_w = shr_w[15:0];
        end

        xs_w   = x_reg >>> step_reg;
        ys_w   = y_reg >>> step_reg;
        atan_w = $signed({{(mch_pkg::ANG_W - mch_pkg::ATAN_W){1'b0}},
                          mch_pkg::atan_entry(step_reg)});

        zadj_w = z_reg + ((z_reg < 0) ? mch_pkg::ANG_W'(65535) : mch_pkg::ANG_W'(0));
        deg_w  = zadj_w[25:16];
        if (deg_w > 10'sd180)
        begin
            deg_w = 10'sd180;
        end
        else if (deg_w < -10'sd180)
        begin
            deg_w = -10'sd180;
        end
        hsum_w = {deg_w[9], deg_w} + {hoff_reg[9], hoff_reg};
        if (hsum_w >= 11'sd360)
        begin
            hrem_w = hsum_w - 11'sd360;
        end
        else if (hsum_w <= -11'sd360)
        begin
            hrem_w = hsum_w + 11'sd360;
        end
        else
        begin
            hrem_w = hsum_w;
        end

        trial_w = {rem_reg, num_reg[mch_pkg::NUM_W-1]};
        qbit_w  = (trial_w >= {1'b0, den_reg});

        sum_mag_w = (sum_reg < 0) ? mch_pkg::SPAN_W'(-sum_reg) : mch_pkg::SPAN_W'(sum_reg);
        h_mag_w   = (h_reg[axis_reg] < 0) ? 16'(-h_reg[axis_reg]) : 16'(h_reg[axis_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tracking_reg <= 1'b0;
            negate_reg   <= 1'b0;
            hoff_reg     <= '0;
            ovalid_reg   <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= '0;
                max_reg[a] <= '0;
                off_reg[a] <= '0;
                wgt_reg[a] <= mch_pkg::WEIGHT_ONE;
            end
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mch_pkg::REG_NEGATE_XY:      negate_reg <= cfg_data[0];
                    mch_pkg::REG_HEADING_OFFSET: hoff_reg   <= $signed(cfg_data);
                    default:                     negate_reg <= negate_reg;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        func_reg <= func;
                        v_reg[0] <= raw_x;
                        v_reg[1] <= raw_y;
                        v_reg[2] <= raw_z;
                        span_reg <= 1'b0;
                        head_reg <= '0;
                        for (int a = 0; a < 3; a++)
                        begin
                            cal_reg[a] <= '0;
                        end
                        priority if (func == mch_pkg::FUNC_SAMPLE)
                        begin
                            state_reg <= ST_PREP;
                        end
                        else if (func == mch_pkg::FUNC_CALIBRATE)
                        begin
                            state_reg <= ST_CALH;
                        end
                        else
                        begin
                            state_reg <= ST_CMD;
                        end
                    end
                end

                ST_PREP:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        mch_pkg::axis_t nv;
                        nv = v_reg[a];
                        if (negate_reg && a < 2)
                        begin
                            nv = (v_reg[a] == 16'sh8000) ? 16'sh7fff : -v_reg[a];
                        end
                        v_reg[a] <= nv;
                        if (tracking_reg)
                        begin
                            if (nv < min_reg[a])
                            begin
                                min_reg[a] <= nv;
                            end
                            if (nv > max_reg[a])
                            begin
                                max_reg[a] <= nv;
                            end
                        end
                    end
                    axis_reg  <= 2'd0;
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    prod_reg  <= mch_pkg::PROD_W'(diff_w)
                               * mch_pkg::PROD_W'($signed({1'b0, wgt_reg[axis_reg]}));
                    state_reg <= ST_SAT;
                end

                ST_SAT:
                begin
                    cal_reg[axis_reg] <= sat_w;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_CINIT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end

                ST_CINIT:
                begin
                    step_reg <= '0;
                    x_reg    <= mch_pkg::VEC_W'(cal_reg[0]) <<< 8;
                    y_reg    <= mch_pkg::VEC_W'(cal_reg[1]) <<< 8;
                    z_reg    <= '0;
                    priority if (cal_reg[1] == 0)
                    begin
                        z_reg     <= (cal_reg[0] < 0) ? mch_pkg::ANG_W'(180 << 16)
                                                      : mch_pkg::ANG_W'(0);
                        state_reg <= ST_HFIN;
                    end
                    else if (cal_reg[0] == 0)
                    begin
                        z_reg     <= (cal_reg[1] > 0) ? mch_pkg::ANG_W'(90 << 16)
                                                      : -mch_pkg::ANG_W'(90 << 16);
                        state_reg <= ST_HFIN;
                    end
                    else if (cal_reg[0] < 0)
                    begin
                        if (cal_reg[1] >= 0)
                        begin
                            x_reg <= mch_pkg::VEC_W'(cal_reg[1]) <<< 8;
                            y_reg <= -(mch_pkg::VEC_W'(cal_reg[0]) <<< 8);
                            z_reg <= mch_pkg::ANG_W'(90 << 16);
                        end
                        else
                        begin
                            x_reg <= -(mch_pkg::VEC_W'(cal_reg[1]) <<< 8);
                            y_reg <= mch_pkg::VEC_W'(cal_reg[0]) <<< 8;
                            z_reg <= -mch_pkg::ANG_W'(90 << 16);
                        end
                        state_reg <= ST_CSTEP;
                    end
                    else
                    begin
                        state_reg <= ST_CSTEP;
                    end
                end

                ST_CSTEP:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + ys_w;
                        y_reg <= y_reg - xs_w;
                        z_reg <= z_reg + atan_w;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys_w;
                        y_reg <= y_reg + xs_w;
                        z_reg <= z_reg - atan_w;
                    end
                    if (step_reg == mch_pkg::STEP_W'(mch_pkg::CORDIC_ITERS - 1))
                    begin
                        state_reg <= ST_HFIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end

                ST_HFIN:
                begin
                    head_reg  <= hrem_w[9:0];
                    state_reg <= ST_OUT;
                end

                ST_CALH:
                begin
                    logic signed [16:0] d;
                    logic signed [16:0] s;
                    logic signed [16:0] hh;
                    logic signed [16:0] oo;
                    logic signed [mch_pkg::SUM_W-1:0] acc;
                    acc = '0;
                    for (int a = 0; a < 3; a++)
                    begin
                        d  = {max_reg[a][15], max_reg[a]} - {min_reg[a][15], min_reg[a]};
                        s  = {max_reg[a][15], max_reg[a]} + {min_reg[a][15], min_reg[a]};
                        hh = (d + ((d < 0) ? 17'sd1 : 17'sd0)) >>> 1;
                        oo = (s + ((s < 0) ? 17'sd1 : 17'sd0)) >>> 1;
                        h_reg[a]   <= hh[15:0];
                        off_reg[a] <= oo[15:0];
                        acc = acc + mch_pkg::SUM_W'(hh);
                    end
                    sum_reg   <= acc;
                    axis_reg  <= 2'd0;
                    state_reg <= ST_DSETUP;
                end

                ST_DSETUP:
                begin
                    priority if (h_reg[axis_reg] == 0)
                    begin
                        wgt_reg[axis_reg] <= mch_pkg::WEIGHT_MAX;
                        span_reg          <= 1'b1;
                        state_reg         <= ST_DDONE;
                    end
                    else if (sum_reg == 0 || ((sum_reg < 0) != (h_reg[axis_reg] < 0)))
                    begin
                        wgt_reg[axis_reg] <= '0;
                        state_reg         <= ST_DDONE;
                    end
                    else
                    begin
                        num_reg   <= {sum_mag_w, {W{1'b0}}};
                        den_reg   <= {1'b0, h_mag_w} + {h_mag_w, 1'b0};
                        rem_reg   <= '0;
                        dcnt_reg  <= mch_pkg::DCNT_W'(mch_pkg::NUM_W);
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    rem_reg  <= qbit_w ? mch_pkg::SPAN_W'(trial_w - {1'b0, den_reg})
                                       : trial_w[mch_pkg::SPAN_W-1:0];
                    num_reg  <= {num_reg[mch_pkg::NUM_W-2:0], qbit_w};
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == mch_pkg::DCNT_W'(1))
                    begin
                        if (|num_reg[mch_pkg::NUM_W-2:mch_pkg::WEIGHT_W-1])
                        begin
                            wgt_reg[axis_reg] <= mch_pkg::WEIGHT_MAX;
                        end
                        else
                        begin
                            wgt_reg[axis_reg] <= {num_reg[mch_pkg::WEIGHT_W-2:0], qbit_w};
                        end
                        state_reg <= ST_DDONE;
                    end
                end

                ST_DDONE:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_DSETUP;
                    end
                end

                ST_CMD:
                begin
                    unique case (func_reg)
                        mch_pkg::FUNC_START:
                        begin
                            tracking_reg <= 1'b1;
                            for (int a = 0; a < 3; a++)
                            begin
                                min_reg[a] <= 16'sh7fff;
                                max_reg[a] <= 16'sh8000;
                            end
                        end
                        mch_pkg::FUNC_STOP:
                        begin
                            tracking_reg <= 1'b0;
                        end
                        mch_pkg::FUNC_CLEAR:
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                off_reg[a] <= '0;
                                wgt_reg[a] <= mch_pkg::WEIGHT_ONE;
                            end
                        end
                        default:
                        begin
                            tracking_reg <= tracking_reg;
                        end
                    endcase
                    state_reg <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        ohead_reg  <= head_reg;
                        ospan_reg  <= span_reg;
                        for (int a = 0; a < 3; a++)
                        begin
                            ocal_reg[a] <= cal_reg[a];
                            omin_reg[a] <= min_reg[a];
                            omax_reg[a] <= max_reg[a];
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### bench/mch_checker.sv
// Checker for the magnetometer calibration and heading block: predicts each output beat.
// Watches the input, output and configuration channels; depends on mch_pkg.
`timescale 1ns / 100ps
module mch_checker
    import mch_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] cal_x,
    input  logic signed [15:0] cal_y,
    input  logic signed [15:0] cal_z,
    input  logic signed [9:0]  heading_deg,
    input  logic signed [15:0] min_x,
    input  logic signed [15:0] max_x,
    input  logic signed [15:0] min_y,
    input  logic signed [15:0] max_y,
    input  logic signed [15:0] min_z,
    input  logic signed [15:0] max_z,
    input  logic               span_error,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [9:0]         cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 samples_seen,
    output int                 calibrations_seen
);

    typedef struct packed {
        logic signed [15:0] cx, cy, cz;
        logic signed [9:0]  hd;
        logic signed [15:0] mnx, mxx, mny, mxy, mnz, mxz;
        logic               se;
    } heading_beat_t;

    heading_beat_t expected_beats[$];

    logic        flip_xy;
    int          turn_offset;
    logic        tracking;
    int          lo[3], hi[3], offs[3], wts[3];

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int compass_angle(int cx, int cy);
        longint x, y, z, t, xs, ys, d;
        z = 0;
        if (cx == 0 && cy == 0) return 0;
        if (cy == 0) return (cx > 0) ? 0 : 180;
        if (cx == 0) return (cy > 0) ? 90 : -90;
        x = longint'(cx) * 256;
        y = longint'(cy) * 256;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += longint'(atan_entry(STEP_W'(i)));
            end
            else
            begin
                x -= ys; y += xs; z -= longint'(atan_entry(STEP_W'(i)));
            end
        end
        d = z / 65536;
        if (d > 180) d = 180;
        if (d < -180) d = -180;
        return int'(d);
    endfunction

    function automatic heading_beat_t predict_heading(logic [2:0] f, int rx, int ry, int rz);
        heading_beat_t r;
        int     v[3], c[3], h[3];
        longint sum, q, p;
        logic   se;
        v[0] = rx; v[1] = ry; v[2] = rz;
        c = '{0, 0, 0};
        se = 1'b0;
        r = '0;
        if (f == FUNC_SAMPLE)
        begin
            if (flip_xy)
            begin
                v[0] = clamp16(-longint'(v[0]));
                v[1] = clamp16(-longint'(v[1]));
            end
            if (tracking)
                for (int a = 0; a < 3; a++)
                begin
                    if (v[a] < lo[a]) lo[a] = v[a];
                    if (v[a] > hi[a]) hi[a] = v[a];
                end
            for (int a = 0; a < 3; a++)
            begin
                p = (longint'(v[a]) - offs[a]) * longint'(wts[a]);
                c[a] = clamp16(p / (longint'(1) << WEIGHT_FRAC_BITS));
            end
            r.hd = 10'((compass_angle(c[0], c[1]) + turn_offset) % 360);
        end
        else if (f == FUNC_START)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = 32767; hi[a] = -32768;
            end
            tracking = 1'b1;
        end
        else if (f == FUNC_STOP)
            tracking = 1'b0;
        else if (f == FUNC_CALIBRATE)
        begin
            sum = 0;
            for (int a = 0; a < 3; a++)
            begin
                h[a] = (hi[a] - lo[a]) / 2;
                offs[a] = (lo[a] + hi[a]) / 2;
                sum += h[a];
            end
            for (int a = 0; a < 3; a++)
                if (h[a] == 0)
                begin
                    wts[a] = 65535; se = 1'b1;
                end
                else
                begin
                    q = (sum * (longint'(1) << WEIGHT_FRAC_BITS)) / (3 * longint'(h[a]));
                    if (q < 0) q = 0;
                    if (q > 65535) q = 65535;
                    wts[a] = int'(q);
                end
        end
        else if (f == FUNC_CLEAR)
            for (int a = 0; a < 3; a++)
            begin
                offs[a] = 0; wts[a] = 1 << WEIGHT_FRAC_BITS;
            end
        r.cx = 16'(c[0]); r.cy = 16'(c[1]); r.cz = 16'(c[2]);
        r.mnx = 16'(lo[0]); r.mxx = 16'(hi[0]);
        r.mny = 16'(lo[1]); r.mxy = 16'(hi[1]);
        r.mnz = 16'(lo[2]); r.mxz = 16'(hi[2]);
        r.se = se;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_beats.size();

    always @(posedge clk or negedge rst_n)
    begin
        heading_beat_t e, g;
        if (!rst_n)
        begin
            flip_xy = 1'b0; turn_offset = 0; tracking = 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = 0; hi[a] = 0; offs[a] = 0; wts[a] = 1 << WEIGHT_FRAC_BITS;
            end
            expected_beats.delete();
            fail_count = 0; samples_seen = 0; calibrations_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NEGATE_XY) flip_xy = cfg_data[0];
                else turn_offset = int'($signed(cfg_data));
            end
            if (out_valid && !out_stall)
            begin
                g = '{cal_x, cal_y, cal_z, heading_deg, min_x, max_x, min_y, max_y,
                      min_z, max_z, span_error};
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (g.cx != e.cx) report_mismatch("cal_x", g.cx, e.cx);
                    if (g.cy != e.cy) report_mismatch("cal_y", g.cy, e.cy);
                    if (g.cz != e.cz) report_mismatch("cal_z", g.cz, e.cz);
                    if (g.hd != e.hd) report_mismatch("heading_deg", g.hd, e.hd);
                    if (g.mnx != e.mnx) report_mismatch("min_x", g.mnx, e.mnx);
                    if (g.mxx != e.mxx) report_mismatch("max_x", g.mxx, e.mxx);
                    if (g.mny != e.mny) report_mismatch("min_y", g.mny, e.mny);
                    if (g.mxy != e.mxy) report_mismatch("max_y", g.mxy, e.mxy);
                    if (g.mnz != e.mnz) report_mismatch("min_z", g.mnz, e.mnz);
                    if (g.mxz != e.mxz) report_mismatch("max_z", g.mxz, e.mxz);
                    if (g.se != e.se) report_mismatch("span_error", g.se, e.se);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_SAMPLE) samples_seen++;
                if (func == FUNC_CALIBRATE) calibrations_seen++;
                expected_beats.push_back(predict_heading(func, raw_x, raw_y, raw_z));
            end
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for the magnetometer calibration and heading block: stimulus and verdict.
// Depends on mch_pkg, mch_checker and the block itself.
`timescale 1ns / 100ps
module tb_top;
    import mch_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         func = FUNC_SAMPLE;
    logic signed [15:0] raw_x = '0, raw_y = '0, raw_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] cal_x, cal_y, cal_z;
    logic signed [9:0]  heading_deg;
    logic signed [15:0] min_x, max_x, min_y, max_y, min_z, max_z;
    logic               span_error;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = REG_NEGATE_XY;
    logic [9:0]         cfg_data = '0;
    int                 fail_count, pending, samples_seen, calibrations_seen;
    int                 send_idle_pct = 0, recv_idle_pct = 0;
    bit                 hold_off = 1'b0;
    longint             cycle_count = 0;

    localparam longint CYCLE_LIMIT = 2000000;

    always #5 clk = ~clk;

    magnetometer_calibrate_heading u_top (.*);

    mch_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    task automatic send_beat(logic [2:0] f, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f; raw_x <= x; raw_y <= y; raw_z <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 4) send_beat(FUNC_START, rand_axis(), rand_axis(), rand_axis());
            else if (r < 7) send_beat(FUNC_STOP, rand_axis(), rand_axis(), rand_axis());
            else if (r < 11) send_beat(FUNC_CALIBRATE, rand_axis(), rand_axis(), rand_axis());
            else if (r < 13) send_beat(FUNC_CLEAR, rand_axis(), rand_axis(), rand_axis());
            else if (r < 15) send_beat(3'($urandom_range(7, 5)), rand_axis(), rand_axis(),
                                       rand_axis());
            else send_beat(FUNC_SAMPLE, rand_axis(), rand_axis(), rand_axis());
        end
    endtask

    task automatic calibration_run(int n);
        send_beat(FUNC_START, '0, '0, '0);
        for (int i = 0; i < n; i++)
            send_beat(FUNC_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
        send_beat(FUNC_STOP, '0, '0, '0);
        send_beat(FUNC_CALIBRATE, '0, '0, '0);
        for (int i = 0; i < 8; i++)
            send_beat(FUNC_SAMPLE, rand_axis(), rand_axis(), rand_axis());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(FUNC_SAMPLE, 16'h7fff, 16'h8000, 16'h0000);
        send_beat(FUNC_SAMPLE, 16'h0000, 16'h0000, 16'h7fff);
        send_beat(FUNC_SAMPLE, 16'h0000, 16'h0005, 16'hffff);
        send_beat(FUNC_SAMPLE, 16'h0000, 16'hfffb, 16'h8000);
        send_beat(FUNC_SAMPLE, 16'hfff0, 16'h0000, 16'h1234);
        send_beat(FUNC_SAMPLE, 16'hfff0, 16'hfff0, 16'h0001);
        send_beat(FUNC_CALIBRATE, '0, '0, '0);
        send_beat(FUNC_SAMPLE, 16'h0100, 16'h0100, 16'h0100);
        send_beat(FUNC_START, '0, '0, '0);
        send_beat(FUNC_CALIBRATE, '0, '0, '0);
        send_beat(FUNC_SAMPLE, 16'h0064, 16'hff9c, 16'h0032);
        send_beat(FUNC_CALIBRATE, '0, '0, '0);
        send_beat(FUNC_SAMPLE, 16'h8000, 16'h7fff, 16'h8000);
        send_beat(FUNC_SAMPLE, 16'h7fff, 16'h8000, 16'h7fff);
        send_beat(FUNC_CALIBRATE, '0, '0, '0);
        send_beat(FUNC_SAMPLE, 16'h0001, 16'h0002, 16'h0003);
        send_beat(FUNC_STOP, '0, '0, '0);
        send_beat(FUNC_CLEAR, '0, '0, '0);
        send_beat(3'd5, 16'hffff, 16'hffff, 16'hffff);
        send_beat(3'd7, '0, '0, '0);
        drain();

        write_reg(REG_NEGATE_XY, 10'd1);
        write_reg(REG_HEADING_OFFSET, 10'(360));
        send_beat(FUNC_SAMPLE, 16'h8000, 16'h8000, 16'h0000);
        send_beat(FUNC_SAMPLE, 16'hffd0, 16'h0030, 16'h0000);
        drain();
        write_reg(REG_HEADING_OFFSET, 10'(-360));
        send_beat(FUNC_SAMPLE, 16'h0030, 16'hffd0, 16'h0000);
        send_beat(FUNC_SAMPLE, 16'h0030, 16'h0030, 16'h0000);
        drain();

        send_idle_pct = 29; recv_idle_pct = 60;
        write_reg(REG_NEGATE_XY, 10'd0);
        write_reg(REG_HEADING_OFFSET, 10'(-97));
        calibration_run(40);
        random_phase(200);
        drain();

        send_idle_pct = 60; recv_idle_pct = 29;
        write_reg(REG_NEGATE_XY, 10'd1);
        write_reg(REG_HEADING_OFFSET, 10'(211));
        calibration_run(40);
        random_phase(200);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(REG_HEADING_OFFSET, 10'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(6);
        join
        end_burst();
        calibration_run(60);
        random_phase(350);
        drain();

        $display("Covered %0d samples and %0d calibrations over several register settings,",
                 samples_seen, calibrations_seen);
        $display("with random idling on both sides and a long output stall.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
